@@ rtl/core/q2e_pkg.sv @@
// Package for the quaternion to Euler converter: widths, angle constants,
// CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;
   localparam int AngW = 32;
   localparam int VecW = 40;
   localparam int TabLen = 24;
   localparam logic signed [AngW-1:0] AngPi = 32'sd843314857;
   localparam logic signed [AngW-1:0] AngHalfPi = 32'sd421657428;
   localparam logic signed [VecW-1:0] OneQ28 = 40'sd268435456;
   localparam logic [1:0] GcNormal = 2'd0;
   localparam logic [1:0] GcPos = 2'd1;
   localparam logic [1:0] GcNeg = 2'd2;

   function automatic logic signed [AngW-1:0] atan_tab(input logic [4:0] i);
      logic signed [AngW-1:0] r;
      case (i)
         5'd0: r = 32'sd210828714;
         5'd1: r = 32'sd124459457;
         5'd2: r = 32'sd65760959;
         5'd3: r = 32'sd33381290;
         5'd4: r = 32'sd16755422;
         5'd5: r = 32'sd8385879;
         5'd6: r = 32'sd4193963;
         5'd7: r = 32'sd2097109;
         5'd8: r = 32'sd1048571;
         5'd9: r = 32'sd524287;
         default: r = 32'sd262144 >>> (i - 5'd10);
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic [1:0] gc;
      logic signed [VecW-1:0] hy;
      logic signed [VecW-1:0] hx;
      logic signed [VecW-1:0] by;
      logic signed [VecW-1:0] bx;
      logic signed [VecW-1:0] ay;
   } front_type;
endpackage
`default_nettype wire

@@ rtl/core/q2e_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module q2e_sqrt #(parameter int SideW = 1) (
   input  wire logic clock,
   input  wire logic adv,
   input  wire logic [29:0] rad,
   input  wire logic [SideW-1:0] side_in,
   output logic [14:0] root,
   output logic [SideW-1:0] side_out
);
   logic [29:0] v_ff [0:15];
   logic [29:0] r_ff [0:15];
   logic [SideW-1:0] s_ff [0:15];
   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff[0] <= rad;
         r_ff[0] <= '0;
         s_ff[0] <= side_in;
      end
   end
   for (genvar k = 0; k < 15; k++) begin : g_st
      logic [31:0] bitv;
      logic [31:0] trial;
      assign bitv = 32'd1 << (2 * (14 - k));
      assign trial = {2'd0, r_ff[k]} + bitv;
      always_ff @(posedge clock) begin
         if (adv) begin
            s_ff[k+1] <= s_ff[k];
            if ({2'd0, v_ff[k]} >= trial) begin
               v_ff[k+1] <= v_ff[k] - trial[29:0];
               r_ff[k+1] <= (r_ff[k] >> 1) + bitv[29:0];
            end else begin
               v_ff[k+1] <= v_ff[k];
               r_ff[k+1] <= r_ff[k] >> 1;
            end
         end
      end
   end
   assign root = r_ff[15][14:0];
   assign side_out = s_ff[15];
endmodule
`default_nettype wire

@@ rtl/core/q2e_cordic.sv @@
// Pipelined vectoring CORDIC atan2, Q28 angle, clamped to +-pi.
// Depends on q2e_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q2e_cordic #(parameter int Stages = 14) (
   input  wire logic clock,
   input  wire logic adv,
   input  wire logic signed [q2e_pkg::VecW-1:0] y_in,
   input  wire logic signed [q2e_pkg::VecW-1:0] x_in,
   output logic signed [q2e_pkg::AngW-1:0] ang
);
   localparam int N = (Stages > q2e_pkg::TabLen) ? q2e_pkg::TabLen : Stages;
   localparam int W = q2e_pkg::VecW + 2;
   logic signed [W-1:0] x_ff [0:N];
   logic signed [W-1:0] y_ff [0:N];
   logic signed [q2e_pkg::AngW+1:0] z_ff [0:N];
   logic zero_ff [0:N];
   logic signed [q2e_pkg::AngW+1:0] zc;
   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff[0] <= (x_in == 0) && (y_in == 0);
         if (x_in < 0) begin
            x_ff[0] <= -W'(x_in);
            y_ff[0] <= -W'(y_in);
            z_ff[0] <= (y_in >= 0) ? (q2e_pkg::AngW+2)'(q2e_pkg::AngPi)
                                   : -(q2e_pkg::AngW+2)'(q2e_pkg::AngPi);
         end else begin
            x_ff[0] <= W'(x_in);
            y_ff[0] <= W'(y_in);
            z_ff[0] <= '0;
         end
      end
   end
   for (genvar i = 0; i < N; i++) begin : g_st
      logic signed [q2e_pkg::AngW+1:0] t;
      assign t = (q2e_pkg::AngW+2)'(q2e_pkg::atan_tab(5'(i)));
      always_ff @(posedge clock) begin
         if (adv) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + t;
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - t;
            end
         end
      end
   end
   always_comb begin
      zc = z_ff[N];
      if (zero_ff[N]) zc = '0;
      else if (zc > (q2e_pkg::AngW+2)'(q2e_pkg::AngPi))
         zc = (q2e_pkg::AngW+2)'(q2e_pkg::AngPi);
      else if (zc < -(q2e_pkg::AngW+2)'(q2e_pkg::AngPi))
         zc = -(q2e_pkg::AngW+2)'(q2e_pkg::AngPi);
   end
   assign ang = zc[q2e_pkg::AngW-1:0];
endmodule
`default_nettype wire

@@ rtl/core/quaternion_to_euler.sv @@
// Quaternion to Euler converter: top level, products, CORDIC lanes, output.
// Depends on q2e_pkg, q2e_sqrt, q2e_cordic.
//
// Usage: a quaternion transfer on req_ (tdata = x, y, z, w, Q1.14) yields
// one transfer on rsp_: heading Q3.12, attitude Q1.12, bank Q2.12, and the
// gimbal case in tuser. csr_ writes the gimbal limit (Q1.14); the user must
// write it only while idle, which is not enforced. Pipeline: 2 product
// stages, 16 square root stages, CORDIC_STAGES+1 CORDIC stages and one output
// register. Throughput: one item per cycle when not stalled; the whole
// pipeline advances in lockstep. When rsp_tready is low with a result
// waiting, the pipeline holds and req_tready drops; nothing is lost or
// repeated. Reset clears all valid bits and loads the limit with 8191.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler #(parameter int CORDIC_STAGES = 14) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [63:0] req_tdata, // quat_x, quat_y, quat_z, quat_w
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [47:0] rsp_tdata, // heading_angle, attitude_angle, bank_angle, pad
   output logic [1:0] rsp_tuser, // gimbal_case
   input  wire logic csr_we,
   input  wire logic [14:0] csr_wdata
);
   localparam int N = (CORDIC_STAGES > q2e_pkg::TabLen) ? q2e_pkg::TabLen
                                                          : CORDIC_STAGES;
   localparam int Depth = 2 + 16 + N + 1;
   localparam int VW = q2e_pkg::VecW;

   logic [14:0] limit_ff;
   logic [Depth-1:0] vld_ff;
   logic adv;
   logic rsp_vld_ff;
   logic [47:0] rsp_data_ff;
   logic [1:0] rsp_gc_ff;

   assign adv = !rsp_vld_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= 15'd8191;
      else if (csr_we) limit_ff <= csr_wdata;
   end

   // stage 1: products
   logic signed [15:0] qx, qy, qz, qw;
   assign qx = req_tdata[15:0];
   assign qy = req_tdata[31:16];
   assign qz = req_tdata[47:32];
   assign qw = req_tdata[63:48];
   logic signed [31:0] xy_ff, zw_ff, yw_ff, xz_ff, yy_ff, zz_ff, xw_ff, yz_ff, xx_ff;
   logic signed [15:0] px_ff, pw_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         xy_ff <= qx * qy; zw_ff <= qz * qw; yw_ff <= qy * qw;
         xz_ff <= qx * qz; yy_ff <= qy * qy; zz_ff <= qz * qz;
         xw_ff <= qx * qw; yz_ff <= qy * qz; xx_ff <= qx * qx;
         px_ff <= qx; pw_ff <= qw;
      end
   end

   // stage 2: sums, gimbal decision, vector setup
   logic signed [VW-1:0] t, lim, a14;
   q2e_pkg::front_type f_in, f_ff;
   always_comb begin
      t = VW'(xy_ff) + VW'(zw_ff);
      lim = VW'({1'b0, limit_ff}) <<< 14;
      a14 = (t <<< 1) >>> 14;
      f_in.ay = a14;
      if (t > lim) f_in.gc = q2e_pkg::GcPos;
      else if (t < -lim) f_in.gc = q2e_pkg::GcNeg;
      else f_in.gc = q2e_pkg::GcNormal;
      if (f_in.gc != q2e_pkg::GcNormal) begin
         f_in.hy = VW'(px_ff);
         f_in.hx = VW'(pw_ff);
      end else begin
         f_in.hy = (VW'(yw_ff) - VW'(xz_ff)) <<< 1;
         f_in.hx = q2e_pkg::OneQ28 - ((VW'(yy_ff) + VW'(zz_ff)) <<< 1);
      end
      f_in.by = (VW'(xw_ff) - VW'(yz_ff)) <<< 1;
      f_in.bx = q2e_pkg::OneQ28 - ((VW'(xx_ff) + VW'(zz_ff)) <<< 1);
   end
   always_ff @(posedge clock) begin
      if (adv) f_ff <= f_in;
   end

   // stage 3: radicand 1 - a^2, floored at zero
   logic signed [19:0] ay_n;
   logic signed [39:0] ay_sq, d_raw;
   logic [29:0] rad;
   assign ay_n = f_ff.ay[19:0];
   assign ay_sq = ay_n * ay_n;
   assign d_raw = q2e_pkg::OneQ28 - ay_sq;
   assign rad = (d_raw < 0) ? '0 : d_raw[29:0];

   // square root; heading and bank vectors ride alongside
   localparam int SW = 2 + 4 * VW + 20;
   logic [14:0] root;
   logic [SW-1:0] s_out;
   q2e_pkg::front_type f2;
   logic [19:0] a_d;
   q2e_sqrt #(.SideW(SW)) u_sqrt (
      .clock(clock), .adv(adv),
      .rad(rad),
      .side_in({f_ff.gc, f_ff.hy, f_ff.hx, f_ff.by, f_ff.bx, f_ff.ay[19:0]}),
      .root(root), .side_out(s_out)
   );
   always_comb begin
      f2 = '0;
      {f2.gc, f2.hy, f2.hx, f2.by, f2.bx, a_d} = s_out;
   end

   logic signed [q2e_pkg::AngW-1:0] ang_h, ang_a, ang_b;
   q2e_cordic #(.Stages(N)) u_head (.clock(clock), .adv(adv),
      .y_in(f2.hy), .x_in(f2.hx), .ang(ang_h));
   q2e_cordic #(.Stages(N)) u_att (.clock(clock), .adv(adv),
      .y_in(VW'($signed(a_d))), .x_in(VW'({1'b0, root})), .ang(ang_a));
   q2e_cordic #(.Stages(N)) u_bank (.clock(clock), .adv(adv),
      .y_in(f2.by), .x_in(f2.bx), .ang(ang_b));

   logic [1:0] gc_ff [0:N];
   always_ff @(posedge clock) begin
      if (adv) gc_ff[0] <= f2.gc;
   end
   for (genvar i = 0; i < N; i++) begin : g_gc
      always_ff @(posedge clock) begin
         if (adv) gc_ff[i+1] <= gc_ff[i];
      end
   end

   // finish: gimbal select, clamp, round
   logic [1:0] gcf;
   logic signed [33:0] h, a, b;
   logic signed [33:0] hr, ar, br;
   assign gcf = gc_ff[N];
   always_comb begin
      a = 34'(ang_a);
      if (a > 34'(q2e_pkg::AngHalfPi)) a = 34'(q2e_pkg::AngHalfPi);
      if (a < -34'(q2e_pkg::AngHalfPi)) a = -34'(q2e_pkg::AngHalfPi);
      h = 34'(ang_h);
      b = 34'(ang_b);
      if (gcf == q2e_pkg::GcPos) begin
         h = 34'(ang_h) <<< 1; a = 34'(q2e_pkg::AngHalfPi); b = '0;
      end else if (gcf == q2e_pkg::GcNeg) begin
         h = -(34'(ang_h) <<< 1); a = -34'(q2e_pkg::AngHalfPi); b = '0;
      end
      hr = (h + 34'sd32768) >>> 16;
      ar = (a + 34'sd32768) >>> 16;
      br = (b + 34'sd32768) >>> 16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Depth-2:0], req_tvalid};
         rsp_vld_ff <= vld_ff[Depth-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {3'd0, br[14:0], ar[13:0], hr[15:0]};
         rsp_gc_ff <= gcf;
      end
   end
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_gc_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready mismatch");
   a_gc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("bad gimbal code");
endmodule
`default_nettype wire
